FILE: hdl/lzt_pkg.sv
// shared types, constants and the root table of the lms z-score table interpolator
package lzt_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BELOW = 3'd1;
  localparam logic [2:0] ST_ABOVE = 3'd2;
  localparam logic [2:0] ST_LZERO = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  localparam logic signed [23:0] Z_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Z_MIN = 24'sh800000;

  typedef struct packed {
    logic               func;
    logic [7:0]         row_index;
    logic [15:0]        ref_age;
    logic signed [15:0] ref_l;
    logic [23:0]        ref_m;
    logic [15:0]        ref_s;
    logic [23:0]        measurement;
    logic [15:0]        subject_age;
  } item_t;

  typedef struct packed {
    logic  valid;
    logic  is_load;
    item_t item;
  } q_side_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_FIRST, S_LAST, S_SCAN, S_RDA, S_RDB, S_RDC,
    S_IMUL, S_IDIV, S_IWAIT, S_ISTORE, S_CHKL, S_LINIT, S_LITER,
    S_EMUL, S_ECHK, S_EXP, S_PSH, S_FPREP, S_FDIV, S_FWAIT, S_OUT
  } state_t;

  // 2^(2^-k) in q1.30, entry 0 unused
  typedef logic [24:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    n = n_in;
    res = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t   r;
    logic [63:0] v;
    r = '0;
    v = isqrt64(64'd1 << 61);
    r[1] = v[30:0];
    for (int k = 2; k <= 24; k++) begin
      v = isqrt64({v[33:0], 30'b0});
      r[k] = v[30:0];
    end
    return r;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

FILE: hdl/lzt_if.sv
// valid/ready channel interfaces for input items and results
interface lzt_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         row_index;
  logic [15:0]        ref_age;
  logic signed [15:0] ref_l;
  logic [23:0]        ref_m;
  logic [15:0]        ref_s;
  logic [23:0]        measurement;
  logic [15:0]        subject_age;

  modport source(output valid, func, row_index, ref_age, ref_l, ref_m, ref_s,
                 measurement, subject_age, input ready);
  modport sink(input valid, func, row_index, ref_age, ref_l, ref_m, ref_s,
               measurement, subject_age, output ready);
endinterface

interface lzt_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] z_score;
  logic [2:0]         status;

  modport source(output valid, z_score, status, input ready);
  modport sink(input valid, z_score, status, output ready);
endinterface

FILE: hdl/lzt_div.sv
// shared unsigned restoring divider, one quotient bit per cycle
module lzt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd63;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/lzt_front.sv
// front end: accepts transactions, tags loads and queues them for the back end
module lzt_front (
  input  logic             clk,
  input  logic             rst_n,
  lzt_in_if.sink           in_ch,
  input  logic             pop,
  output lzt_pkg::q_side_t q
);
  import lzt_pkg::*;

  item_t          q_mem [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           push;
  logic           take;
  item_t          in_item;

  always_comb begin
    in_item.func        = in_ch.func;
    in_item.row_index   = in_ch.row_index;
    in_item.ref_age     = in_ch.ref_age;
    in_item.ref_l       = in_ch.ref_l;
    in_item.ref_m       = in_ch.ref_m;
    in_item.ref_s       = in_ch.ref_s;
    in_item.measurement = in_ch.measurement;
    in_item.subject_age = in_ch.subject_age;
  end

  assign in_ch.ready = (count_r != QCW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign take        = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? QPW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = take ? QPW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = QCW'(count_r + QCW'(push) - QCW'(take));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_item;
    end
  end

  always_comb begin
    q.valid   = (count_r != '0);
    q.item    = q_mem[rd_ptr_r];
    q.is_load = !q_mem[rd_ptr_r].func;
  end

endmodule

FILE: hdl/lzt_back.sv
// back end: table storage, row search, interpolation, log/exp power and z division
module lzt_back #(
  parameter int MAX_ROWS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [8:0]       table_rows,
  input  lzt_pkg::q_side_t q,
  output logic             pop,
  lzt_out_if.source        out_ch
);
  import lzt_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int CW = (NW > 9) ? NW : 9;

  state_t state_r, state_nxt;

  // table memories
  logic [15:0]        age_mem [MAX_ROWS];
  logic signed [15:0] pl_mem  [MAX_ROWS];
  logic [23:0]        med_mem [MAX_ROWS];
  logic [15:0]        var_mem [MAX_ROWS];
  logic [15:0]        age_q;
  logic signed [15:0] pl_q;
  logic [23:0]        med_q;
  logic [15:0]        var_q;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      wa;
  logic               we;

  item_t              item_r, item_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      lo_r, lo_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [15:0]        a0_r, a0_nxt, a1_r, a1_nxt;
  logic signed [15:0] l0_r, l0_nxt, l1_r, l1_nxt;
  logic [23:0]        m0_r, m0_nxt, m1_r, m1_nxt;
  logic [15:0]        s0_r, s0_nxt, s1_r, s1_nxt;
  logic [1:0]         sel_r, sel_nxt;
  logic signed [42:0] prod_r, prod_nxt;
  logic signed [43:0] interp_r, interp_nxt;
  logic signed [15:0] l_r, l_nxt;
  logic [23:0]        m_r, m_nxt;
  logic [15:0]        s_r, s_nxt;
  logic [23:0]        lx_r, lx_nxt;
  logic [30:0]        mant_r, mant_nxt;
  logic [28:0]        lacc_r, lacc_nxt;
  logic [28:0]        ly_r, ly_nxt;
  logic [4:0]         lit_r, lit_nxt;
  logic               lsecond_r, lsecond_nxt;
  logic signed [45:0] eprod_r, eprod_nxt;
  logic signed [9:0]  ip_r, ip_nxt;
  logic [23:0]        f_r, f_nxt;
  logic [30:0]        er_r, er_nxt;
  logic [4:0]         ek_r, ek_nxt;
  logic [43:0]        p_r, p_nxt;
  logic signed [56:0] num_r, num_nxt;
  logic signed [32:0] den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic signed [23:0] res_z_r, res_z_nxt;
  logic [2:0]         res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [23:0] out_z_r, out_z_nxt;
  logic [2:0]         out_st_r, out_st_nxt;

  logic               div_start;
  logic [63:0]        div_dvd;
  logic [31:0]        div_dvs;
  logic               div_done;
  logic [63:0]        div_quo;

  // combinational helpers
  logic [CW-1:0]      tr_ext, n, last, nm2, idx_inc;
  logic               in_range;
  logic [15:0]        age;
  logic signed [25:0] v0s, v1s, diff_s;
  logic signed [16:0] t_s, span_s;
  logic [42:0]        prod_mag;
  logic [16:0]        span_mag;
  logic signed [43:0] qs;
  logic [4:0]         msb;
  logic [61:0]        sq;
  logic [31:0]        sq_hi;
  logic signed [29:0] ldiff;
  logic signed [45:0] e_tmp;
  logic signed [33:0] e_w;
  logic [61:0]        emul;
  logic [4:0]         fbit;
  logic signed [10:0] sh, nsh;
  logic signed [44:0] pm;
  logic [56:0]        num_mag;
  logic [32:0]        den_mag;

  function automatic logic signed [43:0] div_neg_q(input logic ng, input logic [42:0] mg);
    logic signed [43:0] v;
    v = $signed({1'b0, mg});
    return ng ? -v : v;
  endfunction

  lzt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // effective row count clamped to at least 2 and at most the storage
  always_comb begin
    tr_ext = CW'(table_rows);
    if (tr_ext < CW'(2)) begin
      n = CW'(2);
    end else if (tr_ext > CW'(MAX_ROWS)) begin
      n = CW'(MAX_ROWS);
    end else begin
      n = tr_ext;
    end
    last     = n - CW'(1);
    nm2      = n - CW'(2);
    idx_inc  = idx_r + CW'(1);
    in_range = (CW'(item_r.row_index) < CW'(MAX_ROWS));
    wa       = AW'(CW'(item_r.row_index));
    age      = item_r.subject_age;
  end

  // per-field operands of the interpolation
  always_comb begin
    case (sel_r)
      2'd0: begin
        v0s = 26'(l0_r);
        v1s = 26'(l1_r);
      end
      2'd1: begin
        v0s = $signed({2'b0, m0_r});
        v1s = $signed({2'b0, m1_r});
      end
      default: begin
        v0s = $signed({10'b0, s0_r});
        v1s = $signed({10'b0, s1_r});
      end
    endcase
    diff_s   = v1s - v0s;
    t_s      = $signed({1'b0, age}) - $signed({1'b0, a0_r});
    span_s   = $signed({1'b0, a1_r}) - $signed({1'b0, a0_r});
    prod_mag = prod_r[42] ? 43'(-prod_r) : 43'(prod_r);
    span_mag = span_s[16] ? 17'(-span_s) : 17'(span_s);
    qs       = div_neg_q(neg_r, div_quo[42:0]);
  end

  // log2, exp2 and final-division helpers
  always_comb begin
    msb = '0;
    for (int b = 0; b < 24; b++) begin
      if (lx_r[b]) msb = 5'(b);
    end
    sq      = mant_r * mant_r;
    sq_hi   = sq[61:30];
    ldiff   = $signed({1'b0, ly_r}) - $signed({1'b0, lacc_r});
    e_tmp   = eprod_r + (eprod_r[45] ? 46'sd4095 : 46'sd0);
    e_w     = e_tmp[45:12];
    emul    = er_r * ROOT_TAB[ek_r];
    fbit    = 5'(5'd24 - ek_r);
    sh      = 11'(ip_r) + 11'sd2;
    nsh     = -sh;
    pm      = $signed({1'b0, p_r}) - 45'sd4294967296;
    num_mag = num_r[56] ? 57'(-num_r) : 57'(num_r);
    den_mag = den_r[32] ? 33'(-den_r) : 33'(den_r);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    status_nxt    = status_r;
    a0_nxt = a0_r; a1_nxt = a1_r;
    l0_nxt = l0_r; l1_nxt = l1_r;
    m0_nxt = m0_r; m1_nxt = m1_r;
    s0_nxt = s0_r; s1_nxt = s1_r;
    sel_nxt       = sel_r;
    prod_nxt      = prod_r;
    interp_nxt    = interp_r;
    l_nxt = l_r; m_nxt = m_r; s_nxt = s_r;
    lx_nxt        = lx_r;
    mant_nxt      = mant_r;
    lacc_nxt      = lacc_r;
    ly_nxt        = ly_r;
    lit_nxt       = lit_r;
    lsecond_nxt   = lsecond_r;
    eprod_nxt     = eprod_r;
    ip_nxt        = ip_r;
    f_nxt         = f_r;
    er_nxt        = er_r;
    ek_nxt        = ek_r;
    p_nxt         = p_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    res_z_nxt     = res_z_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_z_nxt     = out_z_r;
    out_st_nxt    = out_st_r;
    pop           = 1'b0;
    ra            = '0;
    we            = 1'b0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q.valid) begin
          pop        = 1'b1;
          item_nxt   = q.item;
          status_nxt = ST_OK;
          state_nxt  = q.is_load ? S_LOAD : S_FIRST;
        end
      end
      S_LOAD: begin
        we         = in_range;
        res_z_nxt  = '0;
        res_st_nxt = ST_OK;
        state_nxt  = S_OUT;
      end
      S_FIRST: begin
        if (age < age_q) begin
          lo_nxt     = '0;
          status_nxt = ST_BELOW;
          state_nxt  = S_RDA;
        end else begin
          ra        = last[AW-1:0];
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (age > age_q) begin
          lo_nxt     = nm2[AW-1:0];
          status_nxt = ST_ABOVE;
          state_nxt  = S_RDA;
        end else begin
          idx_nxt   = CW'(1);
          ra        = AW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // age_q holds the age of row idx
        if (age < age_q) begin
          lo_nxt    = AW'(idx_r - CW'(1));
          state_nxt = S_RDA;
        end else if (idx_r == last) begin
          lo_nxt    = nm2[AW-1:0];
          state_nxt = S_RDA;
        end else begin
          idx_nxt = idx_inc;
          ra      = idx_inc[AW-1:0];
        end
      end
      S_RDA: begin
        ra        = lo_r;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        a0_nxt    = age_q;
        l0_nxt    = pl_q;
        m0_nxt    = med_q;
        s0_nxt    = var_q;
        ra        = AW'(lo_r + AW'(1));
        state_nxt = S_RDC;
      end
      S_RDC: begin
        a1_nxt    = age_q;
        l1_nxt    = pl_q;
        m1_nxt    = med_q;
        s1_nxt    = var_q;
        sel_nxt   = 2'd0;
        state_nxt = S_IMUL;
      end
      S_IMUL: begin
        prod_nxt  = diff_s * t_s;
        state_nxt = S_IDIV;
      end
      S_IDIV: begin
        if (span_s == 17'sd0) begin
          interp_nxt = 44'(v0s);
          state_nxt  = S_ISTORE;
        end else begin
          div_start = 1'b1;
          div_dvd   = 64'(prod_mag);
          div_dvs   = 32'(span_mag);
          neg_nxt   = prod_r[42] ^ span_s[16];
          state_nxt = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (div_done) begin
          interp_nxt = 44'(v0s) + qs;
          state_nxt  = S_ISTORE;
        end
      end
      S_ISTORE: begin
        case (sel_r)
          2'd0: begin
            if (interp_r < -44'sd32768) l_nxt = 16'sh8000;
            else if (interp_r > 44'sd32767) l_nxt = 16'sh7FFF;
            else l_nxt = interp_r[15:0];
          end
          2'd1: begin
            if (interp_r < 44'sd1) m_nxt = 24'd1;
            else if (interp_r > 44'sd16777215) m_nxt = 24'hFFFFFF;
            else m_nxt = interp_r[23:0];
          end
          default: begin
            if (interp_r < 44'sd1) s_nxt = 16'd1;
            else if (interp_r > 44'sd65535) s_nxt = 16'hFFFF;
            else s_nxt = interp_r[15:0];
          end
        endcase
        if (sel_r == 2'd2) begin
          state_nxt = S_CHKL;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_IMUL;
        end
      end
      S_CHKL: begin
        if (l_r == 16'sd0) begin
          res_z_nxt  = '0;
          res_st_nxt = ST_LZERO;
          state_nxt  = S_OUT;
        end else if (item_r.measurement == 24'd0) begin
          if (!l_r[15]) begin
            p_nxt     = '0;
            state_nxt = S_FPREP;
          end else begin
            res_z_nxt  = Z_MIN;
            res_st_nxt = ST_SAT;
            state_nxt  = S_OUT;
          end
        end else begin
          lx_nxt      = item_r.measurement;
          lsecond_nxt = 1'b0;
          state_nxt   = S_LINIT;
        end
      end
      S_LINIT: begin
        mant_nxt  = 31'({7'b0, lx_r} << (5'd30 - msb));
        lacc_nxt  = {msb, 24'b0};
        lit_nxt   = 5'd23;
        state_nxt = S_LITER;
      end
      S_LITER: begin
        // one fraction bit per squaring of the mantissa
        if (sq_hi[31]) begin
          mant_nxt = sq_hi[31:1];
          lacc_nxt = lacc_r + (29'd1 << lit_r);
        end else begin
          mant_nxt = sq_hi[30:0];
        end
        if (lit_r == 5'd0) begin
          if (!lsecond_r) begin
            ly_nxt      = lacc_nxt;
            lx_nxt      = m_r;
            lsecond_nxt = 1'b1;
            state_nxt   = S_LINIT;
          end else begin
            state_nxt = S_EMUL;
          end
        end else begin
          lit_nxt = lit_r - 5'd1;
        end
      end
      S_EMUL: begin
        eprod_nxt = l_r * ldiff;
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        if (e_w >= 34'sd184549376) begin
          res_z_nxt  = l_r[15] ? Z_MIN : Z_MAX;
          res_st_nxt = ST_SAT;
          state_nxt  = S_OUT;
        end else begin
          ip_nxt    = e_w[33:24];
          f_nxt     = e_w[23:0];
          er_nxt    = 31'h4000_0000;
          ek_nxt    = 5'd1;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (f_r[fbit]) er_nxt = emul[60:30];
        if (ek_r == 5'd24) begin
          state_nxt = S_PSH;
        end else begin
          ek_nxt = ek_r + 5'd1;
        end
      end
      S_PSH: begin
        if (!sh[10]) begin
          p_nxt = 44'(er_r) << sh[3:0];
        end else if (nsh >= 11'sd64) begin
          p_nxt = '0;
        end else begin
          p_nxt = 44'(er_r) >> nsh[5:0];
        end
        state_nxt = S_FPREP;
      end
      S_FPREP: begin
        num_nxt   = {pm, 12'b0};
        den_nxt   = l_r * $signed({1'b0, s_r});
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        div_start = 1'b1;
        div_dvd   = 64'(num_mag);
        div_dvs   = den_mag[31:0];
        neg_nxt   = num_r[56] ^ den_r[32];
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done) begin
          res_st_nxt = status_r;
          if (neg_r) begin
            if (div_quo > 64'd8388608) begin
              res_z_nxt  = Z_MIN;
              res_st_nxt = ST_SAT;
            end else begin
              res_z_nxt = 24'(-div_quo);
            end
          end else begin
            if (div_quo > 64'd8388607) begin
              res_z_nxt  = Z_MAX;
              res_st_nxt = ST_SAT;
            end else begin
              res_z_nxt = div_quo[23:0];
            end
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_z_nxt     = res_z_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    lo_r      <= lo_nxt;
    status_r  <= status_nxt;
    a0_r <= a0_nxt; a1_r <= a1_nxt;
    l0_r <= l0_nxt; l1_r <= l1_nxt;
    m0_r <= m0_nxt; m1_r <= m1_nxt;
    s0_r <= s0_nxt; s1_r <= s1_nxt;
    sel_r     <= sel_nxt;
    prod_r    <= prod_nxt;
    interp_r  <= interp_nxt;
    l_r <= l_nxt; m_r <= m_nxt; s_r <= s_nxt;
    lx_r      <= lx_nxt;
    mant_r    <= mant_nxt;
    lacc_r    <= lacc_nxt;
    ly_r      <= ly_nxt;
    lit_r     <= lit_nxt;
    lsecond_r <= lsecond_nxt;
    eprod_r   <= eprod_nxt;
    ip_r      <= ip_nxt;
    f_r       <= f_nxt;
    er_r      <= er_nxt;
    ek_r      <= ek_nxt;
    p_r       <= p_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    neg_r     <= neg_nxt;
    res_z_r   <= res_z_nxt;
    res_st_r  <= res_st_nxt;
    out_z_r   <= out_z_nxt;
    out_st_r  <= out_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      age_mem[wa] <= item_r.ref_age;
      pl_mem[wa]  <= item_r.ref_l;
      med_mem[wa] <= item_r.ref_m;
      var_mem[wa] <= item_r.ref_s;
    end
    age_q <= age_mem[ra];
    pl_q  <= pl_mem[ra];
    med_q <= med_mem[ra];
    var_q <= var_mem[ra];
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.z_score = out_z_r;
  assign out_ch.status  = out_st_r;

endmodule

FILE: hdl/lms_zscore_table_interpolator_core.sv
// top level of the lms z-score table interpolator
//
//  channel | direction | handshake          | payload
//  in_ch   | in        | valid/ready        | func, row_index, ref_*, measurement, subject_age
//  out_ch  | out       | valid/ready        | z_score, status
//  cfg     | in        | cfg_wr_en, no wait | cfg_wr_data = table_rows
//
// a load transaction writes one table row; a convert runs a linear search
// over the n table rows (one memory read per cycle), two log2 passes, an
// exp2 and the shared divider, up to four times per convert
// the front queue holds two transactions, so input is taken while a result waits
// synchronous active-low reset; table contents are not cleared, table_rows resets to 2
module lms_zscore_table_interpolator_core #(
  parameter int MAX_ROWS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  lzt_in_if.sink     in_ch,
  lzt_out_if.source  out_ch
);
  import lzt_pkg::*;

  logic [8:0] table_rows_r, table_rows_nxt;
  q_side_t    q;
  logic       pop;

  assign table_rows_nxt = cfg_wr_en ? cfg_wr_data : table_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_rows_r <= 9'd2;
    end else begin
      table_rows_r <= table_rows_nxt;
    end
  end

  lzt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .q     (q)
  );

  lzt_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_rows (table_rows_r),
    .q          (q),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: hdl/lzt_checker.sv
// port-level assertions for the interpolator and their bind
module lzt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_z,
  input logic [2:0]  out_status
);
  import lzt_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_z) && $stable(out_status))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_SAT)
    else $error("status code out of range");

  a_lzero_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_LZERO |-> out_z == 24'd0)
    else $error("zero power result with nonzero z");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |-> out_z == 24'h7FFFFF || out_z == 24'h800000)
    else $error("saturated result not at a bound");

endmodule

bind lms_zscore_table_interpolator_core lzt_checker u_lzt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_z      (out_ch.z_score),
  .out_status (out_ch.status)
);
